@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the histogram block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition held on every rising clock edge, reset included
`define CHK_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

@@ hw/rtl/hwfh_pkg.sv @@
package hwfh_pkg;

  localparam int BINS = 64;
  localparam int COUNT_BITS = 16;
  localparam int BIN_BITS = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SUM_BITS = 2 * COUNT_BITS + BIN_BITS;
  localparam int W_BITS = 16;
  localparam int PROD_BITS = 2 * COUNT_BITS + 30;
  localparam int CMP_BITS = SUM_BITS + 2 * W_BITS;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [W_BITS-1:0] W_ONE = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMRD,
    ST_SUMACC,
    ST_WRD,
    ST_WGO,
    ST_WSRCH,
    ST_EMIT
  } state_t;

  // true for tab, line feed, vertical tab, form feed, carriage return, space
  function automatic logic is_sep(input logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'd65) && (b <= 8'd90)) ? b + 8'd32 : b;
  endfunction

endpackage

@@ hw/rtl/hashed_word_feature_histogram_top.sv @@
// Hashed word feature histogram. Text bytes arrive as items on start/busy;
// separators (tab to carriage return, space) end words, other bytes are
// lowercased and folded into a 32-bit FNV-1a hash, and each word end bumps
// bin (hash mod 64) in a count memory, saturating at 65535. An ordinary byte
// leaves busy low; a byte that closes a word holds busy while its bin is
// read, bumped and written back. On the byte flagged end_of_text the block
// closes any open word and runs a normalisation pass with busy high: once
// any pending bump is written back, a read-and-accumulate step per bin for
// the sum of squares, then per bin a memory read, search launch, bit-serial
// weight search and emit. Each result is shown for exactly one cycle with
// out_valid and the receiver cannot stall it, so it must be taken on that
// cycle; the last result appears in the first cycle after busy drops. Bins
// are cleared as the last result goes out.
module hashed_word_feature_histogram_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  output logic [5:0]  bin_number,
  output logic [15:0] bin_weight,
  output logic        final_bin
);

  localparam int BB = hwfh_pkg::BIN_BITS;
  localparam int CB = hwfh_pkg::COUNT_BITS;

  // counts memory, valid bits give the cleared value
  logic [CB-1:0] counts [hwfh_pkg::BINS];
  logic [hwfh_pkg::BINS-1:0] valid;
  logic [CB-1:0] rd_data;

  logic [31:0] word_hash;
  logic        inside_word;
  hwfh_pkg::state_t state, state_next;
  logic [BB-1:0] idx;
  logic [hwfh_pkg::SUM_BITS-1:0] sumsq;
  logic [CB-1:0] cur;
  logic [2*CB-1:0] cur_sq;
  logic w_go, w_done;
  logic [15:0] w_val;

  // increment pipeline: bump request then read-modify-write
  logic          inc_req;
  logic [BB-1:0] inc_bin;
  logic          inc_wr;
  logic [BB-1:0] inc_wbin;

  logic accept, sep, close_now;
  logic [7:0]  lb;
  logic [31:0] hash_next;

  assign accept = start && !busy;
  assign sep = hwfh_pkg::is_sep(text_byte);
  assign lb = hwfh_pkg::to_lower(text_byte);
  assign hash_next = (word_hash ^ {24'd0, lb}) * hwfh_pkg::FNV_PRIME;
  assign close_now = sep ? inside_word : 1'b1;

  // read port, one address chosen per cycle
  logic [BB-1:0] rd_addr;
  always_comb begin
    rd_addr = idx;
    if (inc_req) rd_addr = inc_bin;
  end
  logic rd_valid;
  always_ff @(posedge clk) begin
    rd_data  <= counts[rd_addr];
    rd_valid <= valid[rd_addr];
  end
  assign cur = rd_valid ? rd_data : '0;
  assign cur_sq = cur * cur;

  always_ff @(posedge clk) begin
    if (inc_wr && (cur != {CB{1'b1}})) counts[inc_wbin] <= cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_hash   <= hwfh_pkg::FNV_BASIS;
      inside_word <= 1'b0;
      inc_req     <= 1'b0;
      inc_wr      <= 1'b0;
      valid       <= '0;
    end else begin
      inc_wr   <= inc_req;
      inc_wbin <= inc_bin;
      inc_req  <= accept && (sep || end_of_text) && close_now;
      if (inc_wr) valid[inc_wbin] <= 1'b1;
      else if ((state == hwfh_pkg::ST_EMIT) && (idx == BB'(hwfh_pkg::BINS - 1))) valid <= '0;
      if (accept) begin
        if (sep || end_of_text) begin
          word_hash   <= hwfh_pkg::FNV_BASIS;
          inside_word <= 1'b0;
          inc_bin     <= sep ? word_hash[BB-1:0] : hash_next[BB-1:0];
        end else begin
          word_hash   <= hash_next;
          inside_word <= 1'b1;
        end
      end
    end
  end

  // back-to-back bumps to one bin need no read forwarding: busy holds off
  // the next byte until a pending bump is written back, so a bump read
  // sees the prior write because writes land before the next read

  always_comb begin
    state_next = state;
    unique case (state)
      hwfh_pkg::ST_IDLE:   if (accept && end_of_text) state_next = hwfh_pkg::ST_SUMRD;
      hwfh_pkg::ST_SUMRD:  if (!inc_req && !inc_wr) state_next = hwfh_pkg::ST_SUMACC;
      hwfh_pkg::ST_SUMACC:
        state_next = (idx == BB'(hwfh_pkg::BINS - 1)) ? hwfh_pkg::ST_WRD : hwfh_pkg::ST_SUMRD;
      hwfh_pkg::ST_WRD:    state_next = hwfh_pkg::ST_WGO;
      hwfh_pkg::ST_WGO:    state_next = hwfh_pkg::ST_WSRCH;
      hwfh_pkg::ST_WSRCH:  if (w_done) state_next = hwfh_pkg::ST_EMIT;
      hwfh_pkg::ST_EMIT:
        state_next = (idx == BB'(hwfh_pkg::BINS - 1)) ? hwfh_pkg::ST_IDLE : hwfh_pkg::ST_WRD;
      default:             state_next = hwfh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != hwfh_pkg::ST_IDLE) || inc_req || inc_wr;
    w_go = (state == hwfh_pkg::ST_WGO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hwfh_pkg::ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (state == hwfh_pkg::ST_EMIT);
      unique case (state)
        hwfh_pkg::ST_IDLE: begin
          idx   <= '0;
          sumsq <= '0;
        end
        hwfh_pkg::ST_SUMACC: begin
          sumsq <= sumsq + hwfh_pkg::SUM_BITS'(cur_sq);
          idx   <= (idx == BB'(hwfh_pkg::BINS - 1)) ? '0 : idx + 1'b1;
        end
        hwfh_pkg::ST_WRD: ;
        hwfh_pkg::ST_WGO: ;
        hwfh_pkg::ST_WSRCH: ;
        hwfh_pkg::ST_EMIT: begin
          bin_number <= 6'(idx);
          bin_weight <= (sumsq == '0) ? 16'd0 : w_val;
          final_bin  <= (idx == BB'(hwfh_pkg::BINS - 1));
          idx        <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  hwfh_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .go     (w_go),
    .count  (cur),
    .sumsq  (sumsq),
    .done   (w_done),
    .weight (w_val)
  );

endmodule

@@ hw/rtl/hwfh_weight.sv @@
// bit-serial search for floor(32768*c/sqrt(s)), one weight bit per cycle
// trial^2*s comes from running sums by shifts and adds
module hwfh_weight (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [hwfh_pkg::COUNT_BITS-1:0]   count,
  input  logic [hwfh_pkg::SUM_BITS-1:0]     sumsq,
  output logic                              done,
  output logic [hwfh_pkg::W_BITS-1:0]       weight
);

  localparam int STEP_BITS = $clog2(hwfh_pkg::W_BITS);
  localparam int AS_BITS = hwfh_pkg::SUM_BITS + hwfh_pkg::W_BITS;

  logic [hwfh_pkg::PROD_BITS-1:0] rhs;
  logic [hwfh_pkg::W_BITS-1:0]    acc;
  logic [AS_BITS-1:0]             acc_s;
  logic [hwfh_pkg::CMP_BITS-1:0]  acc_sq_s;
  logic [STEP_BITS-1:0]           step;
  logic                           running;
  logic [hwfh_pkg::W_BITS-1:0]    trial;
  logic [hwfh_pkg::CMP_BITS-1:0]  lhs;
  logic [2*hwfh_pkg::COUNT_BITS-1:0] c_sq;

  assign c_sq = count * count;
  assign trial = acc | (hwfh_pkg::W_BITS'(1) << step);
  // shared compare: (acc + 2^k)^2 * s = acc^2*s + 2^(k+1)*acc*s + 2^(2k)*s
  assign lhs = acc_sq_s
             + ((hwfh_pkg::CMP_BITS'(acc_s) << step) << 1)
             + (hwfh_pkg::CMP_BITS'(sumsq) << {step, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (step == '0);
      if (go) begin
        running  <= 1'b1;
        step     <= STEP_BITS'(hwfh_pkg::W_BITS - 1);
        acc      <= '0;
        acc_s    <= '0;
        acc_sq_s <= '0;
        rhs      <= {c_sq, 30'd0};
      end else if (running) begin
        if (lhs <= hwfh_pkg::CMP_BITS'(rhs)) begin
          acc      <= trial;
          acc_s    <= acc_s + (AS_BITS'(sumsq) << step);
          acc_sq_s <= lhs;
        end
        if (step == '0) running <= 1'b0;
        else step <= step - 1'b1;
      end
    end
  end

  assign weight = acc;

endmodule

@@ hw/rtl/hwfh_checker.sv @@
`include "assert_macros.svh"

module hwfh_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        out_valid,
  input logic [5:0]  bin_number,
  input logic [15:0] bin_weight,
  input logic        final_bin
);

  `CHK_IMPL(a_busy_out, clk, rst, out_valid |-> busy || final_bin, "result outside pass")
  `CHK_IMPL(a_wmax, clk, rst, out_valid |-> bin_weight <= 16'd32768, "weight above one")
  `CHK_IMPL(a_final, clk, rst, out_valid && final_bin |-> bin_number == 6'd63, "final bin index")
  `CHK_IMPL(a_order, clk, rst, out_valid && $past(out_valid) |-> 1'b0, "results adjacent")

endmodule

bind hashed_word_feature_histogram_top hwfh_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .out_valid(out_valid),
  .bin_number(bin_number), .bin_weight(bin_weight), .final_bin(final_bin)
);
